>>> rtl/srle_pkg.sv
// Package for the serial RGB LED NZR encoder: payload structs, codes,
// queue status and the bit-to-code-byte encoder. No dependencies.
`default_nettype none

package srle_pkg;

    localparam int LED_COUNT_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CHANNELS      = 3;
    localparam int BITS_PER_CHAN = 8;

    localparam logic [7:0] CODE_ZERO = 8'hC0;
    localparam logic [7:0] CODE_ONE  = 8'hFC;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_SEND  = 1'b1
    } t_cmd_code;

    typedef enum logic {
        ORDER_GRB = 1'b0,
        ORDER_RGB = 1'b1
    } t_color_order;

    typedef struct packed {
        logic       command;
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [63:0] code_bytes;
        logic        last;
    } t_out_item;

    // queued command, pixel already in wire order
    typedef struct packed {
        t_cmd_code   cmd;
        logic [7:0]  led_index;
        logic [23:0] pixel;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [63:0] encode_channel(input logic [7:0] v);
        logic [63:0] word;
        word = '0;
        for (int b = 0; b < BITS_PER_CHAN; b++) begin
            word[b*8 +: 8] = v[b] ? CODE_ONE : CODE_ZERO;
        end
        return word;
    endfunction

endpackage

`default_nettype wire

>>> rtl/srle_front.sv
// Front end: accepts input transactions, applies the color order, drops
// out-of-range pixel writes and pushes commands to the queue. Uses srle_pkg.
`default_nettype none

module srle_front #(
    parameter int LED_COUNT = srle_pkg::LED_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire srle_pkg::t_in_item i_in_data,
    output logic                    o_in_ready,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_data,
    output logic                    o_cfg_ready,
    input  wire srle_pkg::t_q_stat  i_q_stat,
    output logic                    o_push,
    output srle_pkg::t_cmd          o_cmd
);

    srle_pkg::t_color_order r_color_order;
    srle_pkg::t_color_order n_color_order;
    logic                   in_range;
    logic                   is_send;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_stat.full;

    always_comb begin
        n_color_order = r_color_order;
        if (i_cfg_valid && o_cfg_ready) begin
            n_color_order = srle_pkg::t_color_order'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_order <= srle_pkg::ORDER_GRB;
        end else begin
            r_color_order <= n_color_order;
        end
    end

    assign is_send  = (srle_pkg::t_cmd_code'(i_in_data.command) == srle_pkg::CMD_SEND);
    assign in_range = ({1'b0, i_in_data.led_index} < 9'(LED_COUNT));

    // writes past the chain end are consumed and dropped here
    assign o_push = i_in_valid && o_in_ready && (is_send || in_range);

    always_comb begin
        o_cmd.cmd       = srle_pkg::t_cmd_code'(i_in_data.command);
        o_cmd.led_index = i_in_data.led_index;
        unique case (r_color_order)
            srle_pkg::ORDER_RGB:
                o_cmd.pixel = {i_in_data.red, i_in_data.green, i_in_data.blue};
            default:
                o_cmd.pixel = {i_in_data.green, i_in_data.red, i_in_data.blue};
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/srle_fifo.sv
// Small command queue between front and back end of the encoder.
// Register array with head/tail pointers. Uses srle_pkg for the status struct.
`default_nettype none

module srle_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = srle_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [WIDTH-1:0]  i_data,
    input  wire logic              i_pop,
    output logic [WIDTH-1:0]       o_data,
    output srle_pkg::t_q_stat      o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/srle_back.sv
// Back end: holds the pixel store, applies queued writes and walks the store on a
// send, one code word per unstalled cycle, into an output register. Uses srle_pkg.
`default_nettype none

module srle_back #(
    parameter int LED_COUNT = srle_pkg::LED_COUNT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire srle_pkg::t_cmd      i_head,
    input  wire srle_pkg::t_q_stat   i_q_stat,
    output logic                     o_pop,
    output logic                     o_out_valid,
    output srle_pkg::t_out_item      o_out_data,
    input  wire logic                i_out_ready
);

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    logic [23:0]         r_store [LED_COUNT];
    logic [IDX_W-1:0]    r_led, n_led;
    logic [1:0]          r_ch, n_ch;
    logic                r_out_valid, n_out_valid;
    srle_pkg::t_out_item r_out_data;
    logic                can_load;
    logic                store_we;
    logic                emit;
    logic                word_last;
    logic [23:0]         pix;
    logic [7:0]          chan;

    assign can_load  = !r_out_valid || i_out_ready;
    assign word_last = (r_led == IDX_W'(LED_COUNT - 1)) && (r_ch == 2'(srle_pkg::CHANNELS - 1));
    assign pix       = r_store[r_led];

    always_comb begin
        case (r_ch)
            2'd0:    chan = pix[23:16];
            2'd1:    chan = pix[15:8];
            default: chan = pix[7:0];
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        store_we = 1'b0;
        emit     = 1'b0;
        if (!i_q_stat.empty) begin
            if (i_head.cmd == srle_pkg::CMD_WRITE) begin
                store_we = 1'b1;
                o_pop    = 1'b1;
            end else if (can_load) begin
                emit  = 1'b1;
                o_pop = word_last;
            end
        end
    end

    always_comb begin
        n_led       = r_led;
        n_ch        = r_ch;
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
            if (word_last) begin
                n_led = '0;
                n_ch  = '0;
            end else if (r_ch == 2'(srle_pkg::CHANNELS - 1)) begin
                n_ch  = '0;
                n_led = r_led + 1'b1;
            end else begin
                n_ch = r_ch + 1'b1;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led       <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_led       <= n_led;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data.code_bytes <= srle_pkg::encode_channel(chan);
            r_out_data.last       <= word_last;
        end
    end

    // frame starts black after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                r_store[i] <= '0;
            end
        end else if (store_we) begin
            r_store[i_head.led_index[IDX_W-1:0]] <= i_head.pixel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> rtl/serial_rgb_led_nzr_encoder.sv
// Top level of the serial RGB LED NZR encoder: front end, command queue,
// back end with pixel store. Uses srle_pkg, srle_front, srle_fifo, srle_back.
//
//  channel | direction | signals                          | payload
//  --------+-----------+----------------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_ready          | i_in_data  (t_in_item)
//  out     | source    | o_out_valid / i_out_ready        | o_out_data (t_out_item)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready        | i_cfg_data (color order)
//
// One pixel write per cycle is sustained into the store while no send is being walked.
// A send emits 3 * LED_COUNT code words from the store walk, one per cycle unless stalled.
// A two-entry command queue decouples input acceptance from the store walk.
// Synchronous active-low reset clears the store to black and the color order to GRB.
// Output stalls hold the word in the output register and pause the walk.
`default_nettype none

module serial_rgb_led_nzr_encoder #(
    parameter int LED_COUNT = srle_pkg::LED_COUNT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire srle_pkg::t_in_item  i_in_data,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output srle_pkg::t_out_item      o_out_data,
    input  wire logic                i_out_ready,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_data,
    output logic                     o_cfg_ready
);

    localparam int CMD_W = $bits(srle_pkg::t_cmd);

    logic              q_push;
    logic              q_pop;
    srle_pkg::t_cmd    q_in;
    srle_pkg::t_cmd    q_head;
    logic [CMD_W-1:0]  q_head_bits;
    srle_pkg::t_q_stat q_stat;

    srle_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    srle_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (srle_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_head_bits),
        .o_stat  (q_stat)
    );

    assign q_head = srle_pkg::t_cmd'(q_head_bits);

    srle_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_code_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.code_bytes[63:56] == srle_pkg::CODE_ONE ||
                         o_out_data.code_bytes[63:56] == srle_pkg::CODE_ZERO))
        else $error("illegal leading code byte");

endmodule

`default_nettype wire

>>> tb/serial_rgb_led_nzr_encoder_tb.sv
// Testbench for serial_rgb_led_nzr_encoder: drives pixel writes, frame sends and
// color order writes, predicts every NZR code word and checks it in order.
// Depends on srle_pkg and the RTL top level only.
`default_nettype none

module serial_rgb_led_nzr_encoder_tb;

    localparam int LED_COUNT   = srle_pkg::LED_COUNT_DEF;
    localparam int LONG_STALL  = 300;
    localparam int CYCLE_LIMIT = 400_000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    srle_pkg::t_in_item  i_in_data   = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    srle_pkg::t_out_item o_out_data;
    logic                i_out_ready = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                i_cfg_data  = 1'b0;
    logic                o_cfg_ready;

    // stimulus and prediction state
    srle_pkg::t_in_item     cmd_backlog[$];
    srle_pkg::t_color_order order_writes[$];
    srle_pkg::t_out_item    code_words_due[$];
    logic [23:0]            frame_shadow[LED_COUNT];
    srle_pkg::t_color_order wire_order = srle_pkg::ORDER_GRB;
    int                     fail_count = 0;
    int                     cycle_count = 0;
    bit                     idle_on = 1'b1;
    bit                     stall_long = 1'b0;
    bit                     long_done = 1'b0;
    int                     long_cnt = 0;
    int                     in_gap = 0;
    int                     out_gap = 0;

    serial_rgb_led_nzr_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one channel level -> eight code bytes, MSB byte first
    function automatic logic [63:0] nzr_code_word(logic [7:0] level);
        logic [63:0] word;
        word = '0;
        for (int b = 7; b >= 0; b--)
            word = {word[55:0], level[b] ? srle_pkg::CODE_ONE : srle_pkg::CODE_ZERO};
        return word;
    endfunction

    function automatic void take_command(srle_pkg::t_in_item cmd);
        srle_pkg::t_out_item word;
        if (cmd.command == srle_pkg::CMD_WRITE) begin
            if (cmd.led_index < LED_COUNT)
                frame_shadow[cmd.led_index] = (wire_order == srle_pkg::ORDER_RGB) ?
                    {cmd.red, cmd.green, cmd.blue} : {cmd.green, cmd.red, cmd.blue};
        end else begin
            for (int led = 0; led < LED_COUNT; led++) begin
                for (int ch = 0; ch < srle_pkg::CHANNELS; ch++) begin
                    word.code_bytes = nzr_code_word(frame_shadow[led][16 - 8 * ch +: 8]);
                    word.last       = (led == LED_COUNT - 1) &&
                                      (ch == srle_pkg::CHANNELS - 1);
                    code_words_due.push_back(word);
                end
            end
        end
    endfunction

    // sender side: pixel commands and color order writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            in_gap      <= 0;
        end else begin
            if (!i_in_valid || o_in_ready) begin
                if (in_gap != 0) begin
                    in_gap     <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    i_in_data  <= cmd_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        in_gap <= $urandom_range(1, 16);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (order_writes.size() != 0) begin
                    i_cfg_data  <= order_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // receiver side: random stall bursts plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_long && !long_done) begin
            i_out_ready <= 1'b0;
            long_cnt    <= long_cnt + 1;
            if (long_cnt == LONG_STALL)
                long_done <= 1'b1;
        end else if (out_gap != 0) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_gap     <= $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: track accepted transactions, check code words
    always @(posedge i_clk) begin
        srle_pkg::t_out_item want;
        if (!i_rst_n) begin
            foreach (frame_shadow[k])
                frame_shadow[k] = '0;
            wire_order = srle_pkg::ORDER_GRB;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                wire_order = srle_pkg::t_color_order'(i_cfg_data);
            if (i_in_valid && o_in_ready)
                take_command(i_in_data);
            if (o_out_valid && i_out_ready) begin
                if (code_words_due.size() == 0) begin
                    $error("unexpected code word %h last %b",
                           o_out_data.code_bytes, o_out_data.last);
                    fail_count++;
                end else begin
                    want = code_words_due.pop_front();
                    if (o_out_data.code_bytes !== want.code_bytes) begin
                        $error("code_bytes mismatch: expected %h, actual %h",
                               want.code_bytes, o_out_data.code_bytes);
                        fail_count++;
                    end
                    if (o_out_data.last !== want.last) begin
                        $error("last mismatch: expected %b, actual %b",
                               want.last, o_out_data.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // wait until everything queued is accepted and every code word is back
    task automatic settle();
        while (cmd_backlog.size() != 0 || i_in_valid || order_writes.size() != 0 ||
               i_cfg_valid || code_words_due.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_color_order(srle_pkg::t_color_order order);
        settle();
        order_writes.push_back(order);
        settle();
    endtask

    task automatic push_cmd(srle_pkg::t_cmd_code cmd, logic [7:0] idx, logic [7:0] r,
                            logic [7:0] g, logic [7:0] b);
        srle_pkg::t_in_item it;
        it.command   = cmd;
        it.led_index = idx;
        it.red       = r;
        it.green     = g;
        it.blue      = b;
        cmd_backlog.push_back(it);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_random(int count, int send_pct);
        srle_pkg::t_cmd_code cmd;
        logic [7:0]          idx;
        for (int k = 0; k < count; k++) begin
            cmd = ($urandom_range(0, 99) < send_pct) ?
                  srle_pkg::CMD_SEND : srle_pkg::CMD_WRITE;
            idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                  8'($urandom_range(0, LED_COUNT - 1));
            push_cmd(cmd, idx, pick_level(), pick_level(), pick_level());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // black frame after reset, unused fields set on the send
        set_color_order(srle_pkg::ORDER_GRB);
        push_cmd(srle_pkg::CMD_SEND, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_cmd(srle_pkg::CMD_WRITE, 8'd0, 8'hFF, 8'h00, 8'hAA);
        push_cmd(srle_pkg::CMD_WRITE, 8'(LED_COUNT - 1), 8'h00, 8'hFF, 8'h55);
        push_cmd(srle_pkg::CMD_WRITE, 8'(LED_COUNT), 8'hFF, 8'hFF, 8'hFF);
        push_cmd(srle_pkg::CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_cmd(srle_pkg::CMD_WRITE, 8'd3, 8'h12, 8'h34, 8'h56);
        push_cmd(srle_pkg::CMD_SEND, 8'h00, 8'h00, 8'h00, 8'h00);

        // switch order: earlier pixels keep GRB layout
        set_color_order(srle_pkg::ORDER_RGB);
        push_cmd(srle_pkg::CMD_WRITE, 8'd1, 8'hFF, 8'h00, 8'h00);
        push_cmd(srle_pkg::CMD_WRITE, 8'd2, 8'h00, 8'hFF, 8'h00);
        push_cmd(srle_pkg::CMD_WRITE, 8'(LED_COUNT - 1), 8'h81, 8'h7E, 8'hFF);
        push_cmd(srle_pkg::CMD_WRITE, 8'h80, 8'h01, 8'h02, 8'h03);
        push_cmd(srle_pkg::CMD_SEND, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
        push_cmd(srle_pkg::CMD_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
        push_cmd(srle_pkg::CMD_SEND, 8'h00, 8'h00, 8'h00, 8'h00);

        queue_random(30, 15);

        // long receiver hold-off while sends keep coming
        set_color_order(srle_pkg::ORDER_GRB);
        stall_long = 1'b1;
        queue_random(30, 40);

        set_color_order(srle_pkg::ORDER_RGB);
        queue_random(30, 15);
        settle();
        queue_random(15, 20);

        set_color_order(srle_pkg::ORDER_GRB);
        queue_random(30, 15);

        // no idling from here on
        set_color_order(srle_pkg::ORDER_RGB);
        idle_on = 1'b0;
        queue_random(25, 15);
        set_color_order(srle_pkg::ORDER_GRB);
        queue_random(25, 20);
        settle();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
